// File: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// Types and constants of the fit partition allocator
package fpa_pkg;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FIT_MODE = 1'd0;
  localparam cfg_idx_t CFG_PARTS    = 1'd1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [4:0] PARTS_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: rtl/fpa_in_if.sv
// Input channel: load and request words
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  load_index;
  logic [15:0] load_size;
  logic [15:0] request_size;

  modport source (output valid, kind, load_index, load_size, request_size, input ready);
  modport sink   (input valid, kind, load_index, load_size, request_size, output ready);
endinterface

// File: rtl/fpa_out_if.sv
// Result channel: grant words
interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [3:0]  grant_index;
  logic [15:0] grant_size;

  modport source (output valid, granted, grant_index, grant_size, input ready);
  modport sink   (input valid, granted, grant_index, grant_size, output ready);
endinterface

// File: rtl/fit_partition_allocator.sv
// Fixed partition allocator with first, best and worst fit placement
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, load_index, load_size, request_size
//   out_ch   out  valid/ready    granted, grant_index, grant_size
//   cfg      in   cfg_we only    cfg_index, cfg_wdata
//
// A load word is written when it is accepted. A request scans n entries, n being the
// scan length min(partitions_in_use, PARTITIONS): one memory read per entry.
// Reset clears the per-entry valid bits, so every partition reads as free and zero size.
// A finished result sits in the output register; the next word is accepted
// meanwhile, and a request waits at its end until that register frees.
`include "assert_macros.svh"

module fit_partition_allocator #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  fpa_in_if.sink            in_ch,
  fpa_out_if.source         out_ch,
  input  logic              cfg_we,
  input  fpa_pkg::cfg_idx_t cfg_index,
  input  logic [4:0]        cfg_wdata
);
  import fpa_pkg::*;

  localparam int IW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNW = $clog2(PARTITIONS + 1);
  localparam int CW  = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  // configuration
  logic [1:0] fit_mode_r;
  logic [4:0] parts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      parts_r    <= PARTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE: fit_mode_r <= cfg_wdata[1:0];
        CFG_PARTS:    parts_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // partition memory: {allocated mark, size}
  logic [SIZE_BITS:0] mem [PARTITIONS];
  logic               vld_r [PARTITIONS];
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [SIZE_BITS:0] mem_wdata;
  logic [IW-1:0]      rd_addr;
  logic [SIZE_BITS:0] rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // scan state
  state_t                state_r, state_nxt;
  logic [IW-1:0]         cnt_r;
  logic [CNW-1:0]        n_r;
  logic [15:0]           req_r;
  logic                  found_r;
  logic [IW-1:0]         pick_idx_r;
  logic [SIZE_BITS-1:0]  pick_size_r;
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [3:0]            out_index_r;
  logic [15:0]           out_size_r;

  logic                  in_acc;
  logic                  is_load_ok;
  logic                  last;
  logic                  out_free;
  logic [SIZE_BITS-1:0]  e_size;
  logic                  e_mark;
  logic                  fits;
  logic                  take;
  logic [CNW-1:0]        n_new;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign is_load_ok = (32'(in_ch.load_index) < PARTITIONS);
  assign last       = (CNW'(cnt_r) + CNW'(1)) == n_r;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign n_new      = (32'(parts_r) > PARTITIONS) ? CNW'(PARTITIONS) : CNW'(parts_r);

  assign e_size = rd_vld_r ? rd_data_r[SIZE_BITS-1:0] : '0;
  assign e_mark = rd_vld_r && rd_data_r[SIZE_BITS];
  assign fits   = !e_mark && (CW'(e_size) >= CW'(req_r));

  always_comb begin
    take = fits && !found_r;
    if (fits && found_r) begin
      if (fit_mode_r == FIT_BEST) begin
        take = e_size < pick_size_r;
      end else if (fit_mode_r == FIT_WORST) begin
        take = e_size > pick_size_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = pick_idx_r;
    mem_wdata   = {1'b1, pick_size_r};
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (in_ch.kind == KIND_LOAD) begin
            mem_we    = is_load_ok;
            mem_waddr = IW'(in_ch.load_index);
            mem_wdata = {1'b0, SIZE_BITS'(in_ch.load_size)};
          end else begin
            state_nxt = (n_new == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr = cnt_r + IW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          mem_we    = found_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath of the scan
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.kind == KIND_REQUEST) begin
          req_r   <= in_ch.request_size;
          n_r     <= n_new;
          cnt_r   <= '0;
          found_r <= 1'b0;
        end
      end
      S_SCAN: begin
        cnt_r <= cnt_r + IW'(1);
        if (take) begin
          found_r     <= 1'b1;
          pick_idx_r  <= cnt_r;
          pick_size_r <= e_size;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_granted_r <= found_r;
      out_index_r   <= found_r ? 4'(pick_idx_r) : 4'd0;
      out_size_r    <= found_r ? 16'(pick_size_r) : 16'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_granted_r;
  assign out_ch.grant_index = out_index_r;
  assign out_ch.grant_size  = out_size_r;

  `FPA_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "result raised outside done")
  `FPA_ASSERT(a_scan_in_range, state_r == S_SCAN |-> (CNW'(cnt_r) < n_r), "scan index beyond limit")
  `FPA_ASSERT(a_grant_marks, (state_r == S_DONE && out_free && found_r) |=> vld_r[$past(pick_idx_r)], "granted entry not written back")
  `FPA_ASSERT(a_nogrant_zero, (out_valid_r && !out_granted_r) |-> (out_index_r == 4'd0 && out_size_r == 16'd0), "no-grant word not zero")
  `FPA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset left block busy")

endmodule

// File: verif/tb.sv
// Self-checking testbench for the fit partition allocator
`timescale 1ns / 100ps

module tb;
  import fpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WORDS_PER_STEP = 90;
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  typedef struct packed {
    logic        granted;
    logic [3:0]  index;
    logic [15:0] size;
  } grant_t;

  // Tracks the partition table and queues the grant word due for each request
  class alloc_scoreboard;
    logic [15:0] part_size [16];
    bit          part_taken [16];
    logic [1:0]  mode;
    logic [4:0]  in_use;
    grant_t      grants_due [$];
    int          errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        part_size[i]  = '0;
        part_taken[i] = 1'b0;
      end
      mode   = FIT_FIRST;
      in_use = PARTS_RESET;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [4:0] val);
      if (idx == CFG_FIT_MODE) begin
        mode = val[1:0];
      end else begin
        in_use = val;
      end
    endfunction

    function void apply_word(logic kind, logic [3:0] lidx, logic [15:0] lsize,
                             logic [15:0] rsize);
      int     lim;
      int     pick;
      bit     found;
      grant_t g;
      if (kind == KIND_LOAD) begin
        part_size[lidx]  = lsize;
        part_taken[lidx] = 1'b0;
        return;
      end
      lim   = (in_use > 16) ? 16 : in_use;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (!part_taken[i] && part_size[i] >= rsize) begin
          if (!found) begin
            pick  = i;
            found = 1'b1;
            // first fit, and the unused mode, stop at the lowest candidate
            if (mode != FIT_BEST && mode != FIT_WORST) break;
          end else if (mode == FIT_BEST && part_size[i] < part_size[pick]) begin
            pick = i;
          end else if (mode == FIT_WORST && part_size[i] > part_size[pick]) begin
            pick = i;
          end
        end
      end
      if (found) begin
        part_taken[pick] = 1'b1;
        g.granted = 1'b1;
        g.index   = pick[3:0];
        g.size    = part_size[pick];
      end else begin
        g = '0;
      end
      grants_due.push_back(g);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_grant(logic granted, logic [3:0] gidx, logic [15:0] gsize);
      grant_t want;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected grant word: expected none, actual %0b/%0d/%0d",
                 $time, granted, gidx, gsize);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      compare_field("granted", 16'(want.granted), 16'(granted));
      compare_field("grant_index", 16'(want.index), 16'(gidx));
      compare_field("grant_size", want.size, gsize);
    endfunction

    function int pending();
      return grants_due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [4:0] cfg_wdata;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fit_partition_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alloc_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  bit stall_req = 1'b0;
  int quiet     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.apply_word(in_ch.kind, in_ch.load_index, in_ch.load_size, in_ch.request_size);
      if (out_ch.valid && out_ch.ready)
        sb.check_grant(out_ch.granted, out_ch.grant_index, out_ch.grant_size);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_word(logic kind, logic [3:0] lidx, logic [15:0] lsize,
                           logic [15:0] rsize);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.load_index   <= lidx;
    in_ch.load_size    <= lsize;
    in_ch.request_size <= rsize;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic load_word(logic [3:0] lidx, logic [15:0] lsize);
    send_word(KIND_LOAD, lidx, lsize, 16'($urandom));
  endtask

  task automatic request_word(logic [15:0] rsize);
    send_word(KIND_REQUEST, 4'($urandom), 16'($urandom), rsize);
  endtask

  // Drop valid, wait out every grant, then let a trailing load finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 7))
      0: pick_size = '0;
      1: pick_size = '1;
      2, 3: pick_size = 16'($urandom_range(0, 15));
      default: pick_size = 16'($urandom);
    endcase
  endfunction

  task automatic directed_words();
    // zero-size request fits a zero-size partition; nothing else fits after
    request_word(16'd0);
    request_word(16'd1);
    load_word(4'd15, 16'hFFFF);
    load_word(4'd1, 16'd100);
    load_word(4'd2, 16'd50);
    load_word(4'd3, 16'd100);
    request_word(16'hFFFF);
    request_word(16'd60);
    load_word(4'd0, 16'd0);
    drain();
    write_reg(CFG_FIT_MODE, {3'b000, FIT_BEST});
    request_word(16'd40);
    load_word(4'd1, 16'd100);
    request_word(16'd100);
    drain();
    write_reg(CFG_FIT_MODE, {3'b000, FIT_WORST});
    load_word(4'd15, 16'hFFFF);
    request_word(16'd0);
    request_word(16'd0);
    drain();
    write_reg(CFG_FIT_MODE, {3'b000, FIT_UNUSED});
    load_word(4'd9, 16'd7);
    request_word(16'd0);
    drain();
    write_reg(CFG_PARTS, 5'd0);
    request_word(16'd0);
    drain();
    write_reg(CFG_PARTS, 5'd31);
    load_word(4'd5, 16'd7);
    request_word(16'd7);
    drain();
    write_reg(CFG_PARTS, 5'd1);
    write_reg(CFG_FIT_MODE, {3'b000, FIT_BEST});
    load_word(4'd0, 16'd3);
    request_word(16'd3);
  endtask

  task automatic random_words(int count);
    logic       kind;
    logic [3:0] lidx;
    int         span;
    span = (sb.in_use == 0 || sb.in_use > 16) ? 16 : sb.in_use;
    repeat (count) begin
      kind = ($urandom_range(0, 99) < 58) ? KIND_REQUEST : KIND_LOAD;
      // keep most loads inside the scanned range so freed entries get reused
      if ($urandom_range(0, 3) != 0) begin
        lidx = 4'($urandom_range(0, span - 1));
      end else begin
        lidx = 4'($urandom);
      end
      send_word(kind, lidx, pick_size(), pick_size());
    end
  endtask

  task automatic random_setup();
    logic [4:0] n;
    case ($urandom_range(0, 9))
      0: n = 5'd0;
      1: n = 5'd16;
      2: n = 5'd1;
      3: n = 5'($urandom_range(17, 31));
      default: n = 5'($urandom_range(1, 16));
    endcase
    drain();
    write_reg(CFG_FIT_MODE, 5'($urandom_range(0, 3)));
    write_reg(CFG_PARTS, n);
  endtask

  initial begin
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_FIT_MODE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_LOAD;
    in_ch.load_index   <= '0;
    in_ch.load_size    <= '0;
    in_ch.request_size <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 30;
          recv_idle = 51;
        end
        1: begin
          send_idle = 51;
          recv_idle = 30;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int step = 0; step < 4; step++) begin
        random_setup();
        // hold the result side while the sender streams
        if (ph == 2 && step == 1) stall_req = 1'b1;
        random_words(WORDS_PER_STEP);
      end
    end
    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
